/* hdl/edro_pkg.sv */
package edro_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int CordicStepsMax     = 24;
   localparam logic [15:0] PeriodReset = 16'd100;
   localparam logic [0:0] CsrPeriod = 1'b0;
   localparam logic [0:0] CsrMpc    = 1'b1;
   localparam logic signed [35:0] CordicGain = 36'sd652032874;
   localparam logic signed [35:0] HeadScale  = 36'sd187403;

   typedef struct packed {
      logic [31:0]        now_ms;
      logic [15:0]        count_fl;
      logic [15:0]        count_fr;
      logic [15:0]        count_rl;
      logic [15:0]        count_rr;
      logic signed [15:0] heading_cdeg;
   } req_type;

   typedef struct packed {
      logic signed [31:0] speed_fl;
      logic signed [31:0] speed_fr;
      logic signed [31:0] speed_rl;
      logic signed [31:0] speed_rr;
      logic signed [31:0] forward_speed;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
   } rsp_type;

   // Control handed from the sequencer to the lanes.
   typedef struct packed {
      logic start;
      logic zero_e;
   } lane_ctl_type;

   function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
      logic signed [35:0] r;
      begin
         case (i)
            5'd0:  r = 36'sh03243F6A8;
            5'd1:  r = 36'sh01DAC6705;
            5'd2:  r = 36'sh00FADBAFC;
            5'd3:  r = 36'sh007F56EA6;
            5'd4:  r = 36'sh003FEAB76;
            5'd5:  r = 36'sh001FFD55B;
            5'd6:  r = 36'sh000FFFAAA;
            5'd7:  r = 36'sh0007FFF55;
            5'd8:  r = 36'sh0003FFFEA;
            5'd9:  r = 36'sh0001FFFFD;
            5'd10: r = 36'sh0000FFFFF;
            5'd11: r = 36'sh00007FFFF;
            5'd12: r = 36'sh00003FFFF;
            5'd13: r = 36'sh00001FFFF;
            5'd14: r = 36'sh00000FFFF;
            5'd15: r = 36'sh000007FFF;
            5'd16: r = 36'sh000003FFF;
            5'd17: r = 36'sh000001FFF;
            5'd18: r = 36'sh000000FFF;
            5'd19: r = 36'sh0000007FF;
            5'd20: r = 36'sh0000003FF;
            5'd21: r = 36'sh0000001FF;
            5'd22: r = 36'sh0000000FF;
            5'd23: r = 36'sh00000007F;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

/* hdl/encoder_dead_reckoning_odometry.sv */
// Four-wheel encoder odometry. A request word carries a millisecond timestamp, four
// encoder counts and an IMU heading. When fewer than period_ms milliseconds have
// passed since the last update the word is absorbed with no response; otherwise one
// response word returns the four wheel speeds, their mean and the updated X/Y
// position, all Q16.16. One word is handled at a time: four wheel lanes each run a
// bit-serial divider in parallel while a CORDIC iterates the heading, then a merging
// stage averages the speeds and scales the X and Y displacements by 1/1000 in four
// 16-bit digit steps, each a reciprocal multiply.
// Registers: index 0 is period_ms, index 1 is meters_per_count.
module encoder_dead_reckoning_odometry import edro_pkg::*; #(
   parameter int CordicSteps = CordicStepsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam logic [2:0] StIdle = 3'd0, StLanes = 3'd1, StMult = 3'd2,
                          StScale = 3'd3, StDiv = 3'd4, StOut = 3'd5;
   // ceil(2^36 / 1000); exact quotient for every dividend below 2^26.
   localparam logic [26:0] Recip1000 = 27'd68719477;
   localparam logic [25:0] Div1000   = 26'd1000;

   logic [2:0]  state_ff, state_in;
   logic [15:0] period_ff;
   logic [23:0] mpc_ff;
   logic [31:0] last_ms_ff, e_ff;
   logic [15:0] last_cnt_ff [4];
   logic signed [31:0] posx_ff, posy_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;
   logic [3:0]  lane_done_ff;
   logic        cordic_done_ff;
   logic signed [35:0] cos_ff, sin_ff;
   logic signed [31:0] fwd_ff;
   logic signed [67:0] vcx_ff, vcy_ff;
   logic [63:0] prodx_ff, prody_ff;
   logic        negx_ff, negy_ff;
   logic [1:0]  dig_ff;
   logic [9:0]  remx_ff, remy_ff;
   logic [63:0] qx_ff, qy_ff;

   logic [31:0] e_now;
   logic        accept, fire;
   lane_ctl_type lctl;
   logic [15:0] cur [4];
   logic [3:0]  ldone;
   logic signed [31:0] spd [4];
   logic        cdone;
   logic signed [35:0] ccos, csin;
   logic [25:0] stepx, stepy;

   assign req_ready = (state_ff == StIdle) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign accept = req_valid && req_ready;
   assign e_now  = req_data.now_ms - last_ms_ff;
   assign fire   = accept && (e_now >= {16'd0, period_ff});
   assign lctl.start  = fire;
   assign lctl.zero_e = (e_now == '0);
   assign cur[0] = req_data.count_fl; assign cur[1] = req_data.count_fr;
   assign cur[2] = req_data.count_rl; assign cur[3] = req_data.count_rr;

   // Four wheel lanes; right-hand wheels negated. The lanes divide by the elapsed time
   // held from the accepting edge, since the request may change once it is taken.
   for (genvar g = 0; g < 4; g++) begin : g_lane
      edro_wheel_lane u_lane (
         .clock(clock), .reset(reset), .ctl(lctl), .cur(cur[g]),
         .last(last_cnt_ff[g]), .negate((g % 2) == 1), .mpc(mpc_ff),
         .elapsed(e_ff), .done(ldone[g]), .speed(spd[g])
      );
   end

   edro_cordic #(.CordicSteps(CordicSteps)) u_cordic (
      .clock(clock), .reset(reset), .start(fire), .heading(req_data.heading_cdeg),
      .done(cdone), .cos_q30(ccos), .sin_q30(csin)
   );

   // One long-division digit by 1000: the running remainder joined with the next
   // 16 bits of the dividend, divided by a reciprocal multiply.
   function automatic logic [25:0] div1000_step(input logic [9:0] rem,
                                                input logic [15:0] digit);
      logic [25:0] x;
      logic [52:0] p;
      logic [15:0] q;
      logic [25:0] r;
      begin
         x = {rem, digit};
         p = 53'(x) * 53'(Recip1000);
         q = p[51:36];
         r = x - 26'(q) * Div1000;
         return {r[9:0], q};
      end
   endfunction

   // Saturating position update from a sign and a 64-bit quotient.
   function automatic logic signed [31:0] adv(input logic signed [31:0] p,
                                              input logic neg, input logic [63:0] q);
      logic [33:0] qc;
      logic signed [35:0] s;
      begin
         qc = (q > 64'h100000000) ? 34'h100000000 : q[33:0];
         s  = 36'(p) + (neg ? -$signed({2'b00, qc}) : $signed({2'b00, qc}));
         if (s > 36'sh07FFFFFFF)       return 32'sh7FFFFFFF;
         else if (s < -36'sh080000000) return 32'sh80000000;
         else                          return s[31:0];
      end
   endfunction

   logic signed [33:0] sum4;
   logic signed [33:0] fwd_w;
   logic signed [67:0] mx, my;
   logic [67:0] ax, ay;
   always_comb begin
      sum4 = 34'(spd[0]) + 34'(spd[1]) + 34'(spd[2]) + 34'(spd[3]);
      fwd_w = (sum4 + (sum4[33] ? 34'sd3 : 34'sd0)) >>> 2;
      mx = vcx_ff >>> 30;
      my = vcy_ff >>> 30;
      ax = mx[67] ? 68'(-mx) : 68'(mx);
      ay = my[67] ? 68'(-my) : 68'(my);
      // The dividend's most significant digit comes first.
      stepx = div1000_step(remx_ff, prodx_ff[{~dig_ff, 4'hF} -: 16]);
      stepy = div1000_step(remy_ff, prody_ff[{~dig_ff, 4'hF} -: 16]);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle:  if (fire) state_in = StLanes;
         StLanes: if (&lane_done_ff && cordic_done_ff) state_in = StMult;
         StMult:  state_in = StScale;
         StScale: state_in = StDiv;
         StDiv:   if (dig_ff == 2'd3) state_in = StOut;
         StOut:   state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fire) e_ff <= e_now;
      if (cdone) begin
         cos_ff <= ccos; sin_ff <= csin;
      end
      if (state_ff == StLanes) fwd_ff <= fwd_w[31:0];
      vcx_ff <= 68'(fwd_ff) * 68'(cos_ff);
      vcy_ff <= 68'(fwd_ff) * 68'(sin_ff);
      negx_ff <= mx[67]; negy_ff <= my[67];
      prodx_ff <= 64'(ax[35:0] * 36'(e_ff));
      prody_ff <= 64'(ay[35:0] * 36'(e_ff));
      if (state_ff == StScale) begin
         dig_ff <= '0; remx_ff <= '0; remy_ff <= '0;
      end else if (state_ff == StDiv) begin
         dig_ff  <= dig_ff + 1'b1;
         remx_ff <= stepx[25:16]; remy_ff <= stepy[25:16];
         qx_ff   <= {qx_ff[47:0], stepx[15:0]};
         qy_ff   <= {qy_ff[47:0], stepy[15:0]};
      end
      if (state_ff == StOut) begin
         rsp_ff.speed_fl <= spd[0]; rsp_ff.speed_fr <= spd[1];
         rsp_ff.speed_rl <= spd[2]; rsp_ff.speed_rr <= spd[3];
         rsp_ff.forward_speed <= fwd_ff;
         rsp_ff.pos_x <= adv(posx_ff, negx_ff, qx_ff);
         rsp_ff.pos_y <= adv(posy_ff, negy_ff, qy_ff);
      end
      if (reset) begin
         state_ff <= StIdle; period_ff <= PeriodReset; mpc_ff <= '0;
         last_ms_ff <= '0; posx_ff <= '0; posy_ff <= '0;
         for (int k = 0; k < 4; k++) last_cnt_ff[k] <= '0;
         rsp_valid_ff <= 1'b0; lane_done_ff <= '0; cordic_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CsrPeriod: period_ff <= csr_data[15:0];
               CsrMpc:    mpc_ff <= csr_data[23:0];
               default: ;
            endcase
         end
         if (fire) begin
            last_ms_ff <= req_data.now_ms;
            for (int k = 0; k < 4; k++) last_cnt_ff[k] <= cur[k];
            lane_done_ff <= '0; cordic_done_ff <= 1'b0;
         end else begin
            lane_done_ff <= lane_done_ff | ldone;
            if (cdone) cordic_done_ff <= 1'b1;
         end
         if (state_ff == StOut) begin
            posx_ff <= adv(posx_ff, negx_ff, qx_ff);
            posy_ff <= adv(posy_ff, negy_ff, qy_ff);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A word is only taken while nothing is in flight or waiting.
   assert property (@(posedge clock) disable iff (reset)
      accept |-> (state_ff == StIdle) && !rsp_valid_ff)
      else $error("request taken while busy");
   // A response appears only right after the output step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == StOut)
      else $error("response without output step");
   // Position only changes when an update completes.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != StOut) |=> $stable(posx_ff) && $stable(posy_ff))
      else $error("position moved outside update");
endmodule

/* hdl/edro_divider.sv */
// Restoring divider: one quotient bit per cycle, unsigned.
module edro_divider import edro_pkg::*; #(
   parameter int NumW = 56,
   parameter int DenW = 40
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic            done,
   output logic [NumW-1:0] quo
);
   localparam int CntW = $clog2(NumW + 1);
   logic [NumW-1:0] q_ff, q_in;
   logic [DenW:0]   r_ff, r_in;
   logic [DenW-1:0] d_ff, d_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [DenW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DenW-1:0], q_ff[NumW-1]};
      if (start) begin
         q_in = num; r_in = '0; d_in = den;
         cnt_in = CntW'(NumW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

/* hdl/edro_wheel_lane.sv */
// One wheel: signed delta magnitude, numerator, divide by e*256, saturate.
module edro_wheel_lane import edro_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctl_type        ctl,
   input  logic [15:0]         cur,
   input  logic [15:0]         last,
   input  logic                negate,
   input  logic [23:0]         mpc,
   input  logic [31:0]         elapsed,
   output logic                done,
   output logic signed [31:0]  speed
);
   logic signed [17:0] d_raw, d_wrap, d_fin;
   logic [16:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in, zero_ff, zero_in;
   logic [40:0]        prod_ff, prod_in;
   logic               st1_ff, st2_ff;
   logic [55:0]        quo;
   logic               div_done;
   logic signed [32:0] sp;

   always_comb begin
      d_raw = $signed({2'b00, cur}) - $signed({2'b00, last});
      if (d_raw > 18'sd32768)       d_wrap = d_raw - 18'sd65536;
      else if (d_raw < -18'sd32768) d_wrap = d_raw + 18'sd65536;
      else                          d_wrap = d_raw;
      d_fin = negate ? -d_wrap : d_wrap;
      neg_in = d_fin[17];
      mag_in = neg_in ? 17'(-d_fin) : 17'(d_fin);
      zero_in = ctl.zero_e;
      prod_in = 41'(mag_ff) * 41'(mpc);
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         mag_ff <= mag_in; neg_ff <= neg_in; zero_ff <= zero_in;
      end
      prod_ff <= prod_in;
      if (reset) begin
         st1_ff <= 1'b0; st2_ff <= 1'b0;
      end else begin
         st1_ff <= ctl.start; st2_ff <= st1_ff;
      end
   end

   // Numerator times 1000 = (p<<10) - (p<<4) - (p<<3).
   logic [55:0] num;
   assign num = ({15'd0, prod_ff} << 10) - ({15'd0, prod_ff} << 4)
              - ({15'd0, prod_ff} << 3);

   edro_divider #(.NumW(56), .DenW(40)) u_div (
      .clock(clock), .reset(reset), .start(st2_ff), .num(num),
      .den({elapsed, 8'd0}), .done(div_done), .quo(quo)
   );

   always_comb begin
      logic [32:0] qs;
      qs = (quo > 56'h80000000) ? 33'h080000000 : quo[32:0];
      if (zero_ff) sp = '0;
      else if (neg_ff) sp = -$signed(qs);
      else sp = (qs > 33'h07FFFFFFF) ? 33'sh07FFFFFFF : $signed(qs);
   end

   assign done  = div_done;
   assign speed = sp[31:0];
endmodule

/* hdl/edro_cordic.sv */
// Iterated CORDIC rotation, one step per cycle, with heading fold.
module edro_cordic import edro_pkg::*; #(
   parameter int CordicSteps = CordicStepsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] heading,
   output logic               done,
   output logic signed [35:0] cos_q30,
   output logic signed [35:0] sin_q30
);
   localparam int Steps = (CordicSteps < CordicStepsMax) ? CordicSteps : CordicStepsMax;
   logic signed [35:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [4:0]         i_ff, i_in;
   logic               busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;
   logic signed [16:0] h1, h2;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0; flip_in = flip_ff;
      h1 = 17'(heading);
      if (h1 > 17'sd18000)       h1 = h1 - 17'sd36000;
      else if (h1 < -17'sd18000) h1 = h1 + 17'sd36000;
      h2 = h1;
      if (start) begin
         flip_in = 1'b0;
         if (h1 > 17'sd9000) begin
            h2 = h1 - 17'sd18000; flip_in = 1'b1;
         end else if (h1 < -17'sd9000) begin
            h2 = h1 + 17'sd18000; flip_in = 1'b1;
         end
         x_in = CordicGain; y_in = '0;
         z_in = 36'(h2) * HeadScale;
         i_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[35]) begin
            x_in = x_ff - (y_ff >>> i_ff);
            y_in = y_ff + (x_ff >>> i_ff);
            z_in = z_ff - atan_q30(i_ff);
         end else begin
            x_in = x_ff + (y_ff >>> i_ff);
            y_in = y_ff - (x_ff >>> i_ff);
            z_in = z_ff + atan_q30(i_ff);
         end
         i_in = i_ff + 1'b1;
         if (i_ff == 5'(Steps - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in; flip_ff <= flip_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign cos_q30 = flip_ff ? -x_ff : x_ff;
   assign sin_q30 = flip_ff ? -y_ff : y_ff;
endmodule

/* verif/encoder_dead_reckoning_odometry_tb.sv */
// Self-checking bench for the four-wheel encoder odometry block.
// A predictor written in plain SystemVerilog arithmetic tracks the block's state.
// It pushes one expected response word for every request word that should cause an update.
// The monitor checks every response word against the oldest expectation, field by field.
module encoder_dead_reckoning_odometry_tb;
   import edro_pkg::*;

   localparam int CycleLimit = 600000;
   // The drain wait is long enough to cover any word that may still be in flight.
   localparam int DrainCycles = 300;
   localparam int RandomItems = 450;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [31:0] csr_data;

   encoder_dead_reckoning_odometry uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // The predictor keeps its own copy of the configuration and of the odometry state.
   logic [15:0]        cfg_period;
   logic [23:0]        cfg_mpc;
   logic [31:0]        odo_last_ms;
   logic [15:0]        odo_last_cnt [4];
   logic signed [31:0] odo_x;
   logic signed [31:0] odo_y;

   rsp_type pending_rsp [$];
   int      cycles = 0;
   int      mismatches = 0;
   int      responses_seen = 0;
   int      words_sent = 0;
   int      rsp_hold = 0;
   bit      calm = 1'b0;

   // Arctangent table for the rotation steps, Q1.30 radians, truncated.
   longint atan_tab [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   function automatic logic signed [31:0] sat_word(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Speed of one wheel from its count delta, with 16-bit wrap correction applied first.
   function automatic logic signed [31:0] wheel_rate(input logic [15:0] cur,
                                                     input logic [15:0] prev,
                                                     input bit right_side,
                                                     input logic [31:0] e);
      int d;
      longint unsigned mag, q;
      bit neg;
      d = int'(cur) - int'(prev);
      if (d > 32768) d -= 65536;
      else if (d < -32768) d += 65536;
      if (right_side) d = -d;
      if (e == 0) return '0;
      neg = d < 0;
      mag = neg ? longint'(-d) : longint'(d);
      q = (mag * longint'(cfg_mpc) * 64'd1000) / (longint'(e) * 64'd256);
      if (q > 64'h80000000) q = 64'h80000000;
      if (!neg && q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
      return neg ? sat_word(-longint'(q)) : q[31:0];
   endfunction

   // Cosine and sine of the heading, Q1.30, from the iterated rotation.
   task automatic heading_cos_sin(input logic signed [15:0] hd, output longint c,
                                  output longint s);
      int h;
      bit flip;
      longint x, y, z, nx;
      h = hd;
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (h > 18000) h -= 36000;
      else if (h < -18000) h += 36000;
      if (h > 9000) begin
         h -= 18000;
         flip = 1'b1;
      end else if (h < -9000) begin
         h += 18000;
         flip = 1'b1;
      end
      z = longint'(h) * 187403;
      for (int i = 0; i < CordicStepsDefault && i < CordicStepsMax; i++) begin
         // The arithmetic shift of a signed value rounds toward minus infinity.
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= atan_tab[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += atan_tab[i];
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic signed [31:0] step_pos(input logic signed [31:0] pos,
                                                   input logic signed [31:0] v,
                                                   input longint trig,
                                                   input logic [31:0] e);
      longint vc, stp;
      longint unsigned mag, q;
      vc = (longint'(v) * trig) >>> 30;
      mag = (vc < 0) ? -vc : vc;
      q = (mag * longint'(e)) / 64'd1000;
      if (q > 64'h100000000) q = 64'h100000000;
      stp = (vc < 0) ? -longint'(q) : longint'(q);
      return sat_word(longint'(pos) + stp);
   endfunction

   // Predict the response word, if any, for one accepted request word and update the state.
   task automatic odometry_predict(input req_type w, output bit fired, output rsp_type r);
      logic [31:0] e;
      longint c, s, sum;
      e = w.now_ms - odo_last_ms;
      fired = e >= cfg_period;
      r = '0;
      if (fired) begin
         odo_last_ms = w.now_ms;
         r.speed_fl = wheel_rate(w.count_fl, odo_last_cnt[0], 1'b0, e);
         r.speed_fr = wheel_rate(w.count_fr, odo_last_cnt[1], 1'b1, e);
         r.speed_rl = wheel_rate(w.count_rl, odo_last_cnt[2], 1'b0, e);
         r.speed_rr = wheel_rate(w.count_rr, odo_last_cnt[3], 1'b1, e);
         odo_last_cnt[0] = w.count_fl;
         odo_last_cnt[1] = w.count_fr;
         odo_last_cnt[2] = w.count_rl;
         odo_last_cnt[3] = w.count_rr;
         sum = longint'(r.speed_fl) + r.speed_fr + r.speed_rl + r.speed_rr;
         r.forward_speed = sum / 4;
         heading_cos_sin(w.heading_cdeg, c, s);
         odo_x = step_pos(odo_x, r.forward_speed, c, e);
         odo_y = step_pos(odo_y, r.forward_speed, s, e);
         r.pos_x = odo_x;
         r.pos_y = odo_y;
      end
   endtask

   // Response side: random back-pressure, and a check of every response word.
   string field_names [7] = '{"speed_fl", "speed_fr", "speed_rl", "speed_rr",
                              "forward_speed", "pos_x", "pos_y"};

   always @(posedge clock) begin
      rsp_type want;
      logic [31:0] fw, fg;
      bit bad;
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles,
                  pending_rsp.size());
         $display("encoder_dead_reckoning_odometry regression: fail");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response word %h", rsp_data);
            end else begin
               want = pending_rsp.pop_front();
               bad = 1'b0;
               for (int i = 0; i < 7; i++) begin
                  fw = want[223 - 32*i -: 32];
                  fg = rsp_data[223 - 32*i -: 32];
                  if (fw !== fg) begin
                     bad = 1'b1;
                     if (mismatches < 10)
                        $display("response %0d %s: expected %h got %h", responses_seen,
                                 field_names[i], fw, fg);
                  end
               end
               if (bad) mismatches++;
            end
            rsp_hold = calm ? 0 : $urandom_range(0, 14);
            rsp_ready <= (rsp_hold == 0);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= (rsp_hold == 0);
         end
      end
   end

   // Configuration writes happen only while the block is idle.
   task automatic wait_idle();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CsrPeriod) cfg_period = value[15:0];
      else cfg_mpc = value[23:0];
   endtask

   task automatic configure(input logic [15:0] period, input logic [23:0] mpc);
      wait_idle();
      csr_write(CsrPeriod, {16'h0, period});
      csr_write(CsrMpc, {8'h0, mpc});
   endtask

   // Send one request word and return once it has been accepted.
   // When the caller supplies a typed expectation it is queued instead of the predicted one.
   task automatic send_word(input req_type w, input bit typed, input bit typed_fires,
                            input rsp_type typed_rsp);
      int gap;
      bit fired;
      rsp_type r;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      odometry_predict(w, fired, r);
      if (typed) begin
         if (typed_fires) pending_rsp.push_back(typed_rsp);
      end else if (fired) begin
         pending_rsp.push_back(r);
      end
   endtask

   task automatic idle_req();
      req_valid <= 1'b0;
   endtask

   typedef struct {
      bit          wr_cfg;
      logic [15:0] period;
      logic [23:0] mpc;
      req_type     word;
      bit          typed;
      bit          typed_fires;
   } directed_row;

   // The directed rows cover the cases that can be read off at a glance.
   // Right after reset the travel per count is zero, so every update reports all zeros.
   // Words that arrive too early cause no response at all.
   // The remaining rows cover full-scale deltas, a repeated timestamp with no period,
   // headings at and beyond the quadrant edges, timestamp wrap and the longest period.
   directed_row drows [] = '{
      '{0, 16'd100, 24'd0, '{32'd50, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'sd0}, 1, 0},
      '{0, 16'd100, 24'd0,
        '{32'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sd18000}, 1, 1},
      '{0, 16'd100, 24'd0, '{32'd150, 16'h1234, 16'h0, 16'h0, 16'h0, 16'sd0}, 1, 0},
      '{1, 16'd0, 24'hFFFFFF,
        '{32'd101, 16'h7FFF, 16'h7FFE, 16'h0000, 16'hFFFE, -16'sd18000}, 0, 0},
      '{0, 16'd0, 24'hFFFFFF,
        '{32'd101, 16'h1000, 16'h2000, 16'h3000, 16'h4000, 16'sd0}, 0, 0},
      '{0, 16'd0, 24'hFFFFFF,
        '{32'd1101, 16'h1800, 16'h1800, 16'h3800, 16'h3800, 16'sh7FFF}, 0, 0},
      '{0, 16'd0, 24'hFFFFFF,
        '{32'd6101, 16'h9800, 16'h9800, 16'hB800, 16'hB800, 16'sh8000}, 0, 0},
      '{0, 16'd0, 24'hFFFFFF,
        '{32'd6201, 16'h9900, 16'h9700, 16'hB900, 16'hB700, 16'sd9000}, 0, 0},
      '{0, 16'd0, 24'hFFFFFF,
        '{32'd6301, 16'h9A00, 16'h9600, 16'hBA00, 16'hB600, -16'sd9000}, 0, 0},
      '{0, 16'd0, 24'hFFFFFF,
        '{32'd6401, 16'h9B00, 16'h9500, 16'hBB00, 16'hB500, 16'sd9001}, 0, 0},
      '{0, 16'd0, 24'hFFFFFF,
        '{32'd6501, 16'h9C00, 16'h9400, 16'hBC00, 16'hB400, -16'sd9001}, 0, 0},
      '{0, 16'd0, 24'hFFFFFF,
        '{32'hFFFFFFF0, 16'h1C00, 16'h1400, 16'h3C00, 16'h3400, 16'sd4500}, 0, 0},
      '{0, 16'd0, 24'hFFFFFF,
        '{32'h00000010, 16'h1C10, 16'h13F0, 16'h3C10, 16'h33F0, -16'sd4500}, 0, 0},
      '{1, 16'd65535, 24'd1,
        '{32'd65544, 16'h0, 16'h0, 16'h0, 16'h0, 16'sd0}, 0, 0},
      '{0, 16'd65535, 24'd1,
        '{32'd65551, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'sd100}, 0, 0}
   };

   logic [31:0] stim_now;
   logic [15:0] stim_cnt [4];

   // Build one random request word.  Most words are well formed, arriving at least one
   // period after the previous one with moderate count deltas.  The rest arrive too early,
   // jump to random values, or carry near full-scale deltas.
   function automatic req_type random_word();
      req_type w;
      int kind;
      int spread;
      kind = $urandom_range(0, 99);
      w.now_ms = stim_now + cfg_period + $urandom_range(0, 300);
      for (int i = 0; i < 4; i++) begin
         spread = $urandom_range(0, 4000);
         stim_cnt[i] = stim_cnt[i] + 16'(spread - 2000);
      end
      if (kind >= 70 && kind < 80) begin
         w.now_ms = stim_now + $urandom_range(0, cfg_period);
      end else if (kind >= 80 && kind < 90) begin
         w.now_ms = $urandom();
         for (int i = 0; i < 4; i++) stim_cnt[i] = 16'($urandom());
      end else if (kind >= 90) begin
         for (int i = 0; i < 4; i++)
            stim_cnt[i] = stim_cnt[i] + 16'(32768 + $urandom_range(0, 6) - 3);
      end
      w.count_fl = stim_cnt[0];
      w.count_fr = stim_cnt[1];
      w.count_rl = stim_cnt[2];
      w.count_rr = stim_cnt[3];
      if ($urandom_range(0, 9) == 0) w.heading_cdeg = 16'($urandom());
      else w.heading_cdeg = 16'($urandom_range(0, 36000)) - 16'sd18000;
      stim_now = w.now_ms;
      return w;
   endfunction

   initial begin
      rsp_type zero_rsp;
      logic [23:0] mpc_pick;
      logic [15:0] per_pick;
      int phase;
      zero_rsp = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cfg_period = PeriodReset;
      cfg_mpc = '0;
      odo_last_ms = '0;
      odo_x = '0;
      odo_y = '0;
      for (int i = 0; i < 4; i++) odo_last_cnt[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (drows[k]) begin
         if (drows[k].wr_cfg) begin
            idle_req();
            configure(drows[k].period, drows[k].mpc);
         end
         send_word(drows[k].word, drows[k].typed, drows[k].typed_fires, zero_rsp);
         stim_now = drows[k].word.now_ms;
      end
      for (int i = 0; i < 4; i++) stim_cnt[i] = odo_last_cnt[i];

      // Random phases, each with its own setting.  Long periods are rare so runs stay short.
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin per_pick = 16'd0;  mpc_pick = 24'hFFFFFF; end
            1: begin per_pick = 16'd100; mpc_pick = 24'd0; end
            2: begin per_pick = 16'd65535; mpc_pick = 24'($urandom()); end
            default: begin
               per_pick = 16'($urandom_range(0, 400));
               mpc_pick = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 20000))
                                                      : 24'($urandom());
            end
         endcase
         calm = (phase == 4);
         idle_req();
         configure(per_pick, mpc_pick);
         for (int n = 0; n < ((phase == 2) ? 20 : RandomItems / 5); n++)
            send_word(random_word(), 1'b0, 1'b0, zero_rsp);
      end
      idle_req();

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("sent %0d request words and checked %0d response words", words_sent,
               responses_seen);
      $display("settings swept both period and travel per count from zero to full scale");
      if (mismatches == 0) begin
         $display("encoder_dead_reckoning_odometry regression: pass");
      end else begin
         $display("%0d mismatching response words", mismatches);
         $display("encoder_dead_reckoning_odometry regression: fail");
      end
      $finish;
   end

endmodule
